>>> rtl/igs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igs_pkg
// types and constants shared by the ising gibbs site update block
// ----------------------------------------------------------------------------
package igs_pkg;

  // item opcodes
  typedef enum logic [1:0] {
    OP_WR_COUPLING  = 2'd0,
    OP_WR_THRESHOLD = 2'd1,
    OP_WR_SPIN      = 2'd2,
    OP_UPDATE       = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BETA      = 2'd0;
  localparam logic [1:0] CFG_LOW_RESP  = 2'd1;
  localparam logic [1:0] CFG_HIGH_RESP = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] BETA_RESET      = 16'd4096;
  localparam logic [1:0]  LOW_RESP_RESET  = 2'b11;
  localparam logic [1:0]  HIGH_RESP_RESET = 2'b01;

  // shared divider geometry: q1.62 dividends, divisors up to 2^47
  localparam int DIVIDEND_W = 63;
  localparam int DIVISOR_W  = 48;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // index of the last term in the exp(-1/16) series
  localparam logic [4:0] SERIES_LAST = 5'd23;
  // largest sigmoid magnitude in sixteenths
  localparam logic [8:0] MAG_LAST    = 9'd256;

  typedef enum logic [3:0] {
    ST_SER_GO,
    ST_SER_WAIT,
    ST_POS_GO,
    ST_POS_WAIT,
    ST_NEG_GO,
    ST_NEG_WAIT,
    ST_EXP_MUL,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_ACC,
    ST_UPD_BETA,
    ST_UPD_PROD,
    ST_UPD_SAT,
    ST_UPD_SPIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/igs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igs channel interfaces
// valid/ready channels for items, results and configuration words
// ----------------------------------------------------------------------------
interface igs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  site_index;
  logic [4:0]  neighbour_index;
  logic signed [15:0] weight_value;
  logic        spin_bit;
  logic        pin_flag;
  logic [15:0] uniform_draw;

  modport source (output valid, opcode, site_index, neighbour_index, weight_value,
                  spin_bit, pin_flag, uniform_draw, input ready);
  modport sink   (input valid, opcode, site_index, neighbour_index, weight_value,
                  spin_bit, pin_flag, uniform_draw, output ready);
endinterface

interface igs_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  site_out;
  logic        spin_high;
  logic [15:0] probability;
  logic signed [22:0] local_field;

  modport source (output valid, site_out, spin_high, probability, local_field,
                  input ready);
  modport sink   (input valid, site_out, spin_high, probability, local_field,
                  output ready);
endinterface

interface igs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ising_gibbs_site_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_gibbs_site_update_top
// single-site gibbs sampler for an ising model with a sigmoid probability rom
// ----------------------------------------------------------------------------
//  channel   dir   word                                            handshake
//  in_chan   in    opcode, site, neighbour, weight, spin, pin, draw valid/ready
//  out_chan  out   site, spin_high, probability, local_field       valid/ready
//  cfg_chan  in    register index, data                            valid/ready
//
//  a write item passes straight to the result state; an update streams the
//  coupling column through the coupling memory read port, one coupling per cycle
//  after reset a fill pass builds the sigmoid rom with the shared divider and
//  multiplier; in_chan.ready stays low until it ends
//  cfg_chan is always ready; a result waits in the output register while the
//  next word is accepted, and the block holds in its result state until the
//  output register is free
// ----------------------------------------------------------------------------
module ising_gibbs_site_update_top import igs_pkg::*; #(
  parameter int NUM_SITES = 32
) (
  input  logic clk,
  input  logic rst_n,
  igs_in_if.sink    in_chan,
  igs_out_if.source out_chan,
  igs_cfg_if.sink   cfg_chan
);

  localparam int SW        = $clog2(NUM_SITES);
  localparam int CPL_DEPTH = NUM_SITES << SW;

  // state and datapath registers
  state_t                 state_r, state_nxt;
  logic [DIVIDEND_W-1:0]  term_r, term_nxt;      // series term
  logic [DIVIDEND_W-1:0]  csum_r, csum_nxt;      // exp(-1/16) in q1.62
  logic [4:0]             n_r, n_nxt;            // series index
  logic [DIVIDEND_W-1:0]  e_r, e_nxt;            // exp(-m/16) in q1.62
  logic [8:0]             m_r, m_nxt;            // magnitude in sixteenths
  logic [125:0]           pacc_r, pacc_nxt;      // partial product sum
  logic [2:0]             pp_cnt_r, pp_cnt_nxt;
  logic signed [65:0]     mul_r;
  logic signed [32:0]     mul_a, mul_b;

  logic [15:0]            beta_r, beta_nxt;
  logic [1:0]             lresp_r, lresp_nxt;
  logic [1:0]             hresp_r, hresp_nxt;

  logic [NUM_SITES-1:0]   spin_r, spin_nxt;
  logic [NUM_SITES-1:0]   pin_r, pin_nxt;

  logic [4:0]             site_r, site_nxt;
  logic [SW-1:0]          site_sw_r, site_sw_nxt;
  logic                   in_range_r, in_range_nxt;
  logic [15:0]            draw_r, draw_nxt;
  logic [SW-1:0]          j_r, j_nxt;
  logic signed [24:0]     facc_r, facc_nxt;
  logic signed [22:0]     field_r, field_nxt;
  logic [15:0]            prob_r, prob_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [4:0]             out_site_r, out_site_nxt;
  logic                   out_spin_r, out_spin_nxt;
  logic [15:0]            out_prob_r, out_prob_nxt;
  logic signed [22:0]     out_field_r, out_field_nxt;

  // memories
  logic [15:0]            rom [512];
  logic                   rom_we;
  logic [8:0]             rom_waddr, rom_raddr;
  logic [15:0]            rom_wdata, rom_q_r;

  logic signed [15:0]     cpl_mem [CPL_DEPTH];
  logic                   cpl_we;
  logic [2*SW-1:0]        cpl_waddr, cpl_raddr;
  logic signed [15:0]     cpl_q_r;

  logic signed [15:0]     thr_mem [NUM_SITES];
  logic                   thr_we;
  logic signed [15:0]     thr_q_r;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   in_acc;

  igs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.site_out    = out_site_r;
  assign out_chan.spin_high   = out_spin_r;
  assign out_chan.probability = out_prob_r;
  assign out_chan.local_field = out_field_r;

  // configuration registers
  always_comb begin
    beta_nxt  = beta_r;
    lresp_nxt = lresp_r;
    hresp_nxt = hresp_r;
    if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        CFG_BETA:      beta_nxt  = cfg_chan.data;
        CFG_LOW_RESP:  lresp_nxt = cfg_chan.data[1:0];
        CFG_HIGH_RESP: hresp_nxt = cfg_chan.data[1:0];
        default:       ;
      endcase
    end
  end

  // sequencer: rom fill pass, item dispatch and the update loop
  always_comb begin
    logic [DIVISOR_W-1:0] den;
    logic [6:0]           site_ext;
    logic [6:0]           nb_ext;
    logic                 site_ok;
    logic                 nb_ok;
    logic [SW-1:0]        site_sw;
    logic [SW-1:0]        nb_sw;
    logic [2:0]           kk;
    logic [1:0]           sh;
    logic [125:0]         pp_ext;
    logic [1:0]           resp;
    logic signed [24:0]   wext;
    logic signed [24:0]   cterm;
    logic signed [24:0]   base;
    logic signed [24:0]   fsum;
    logic [2:0]           diff;
    logic [41:0]          prod;
    logic [8:0]           qsat;
    logic                 load_out;

    den      = (DIVISOR_W'(1) << 46) + {1'b0, e_r[DIVIDEND_W-1:16]};
    site_ext = {2'b00, in_chan.site_index};
    nb_ext   = {2'b00, in_chan.neighbour_index};
    site_ok  = site_ext < 7'(NUM_SITES);
    nb_ok    = nb_ext < 7'(NUM_SITES);
    site_sw  = site_ext[SW-1:0];
    nb_sw    = nb_ext[SW-1:0];
    kk       = pp_cnt_r - 3'd1;
    sh       = {1'b0, kk[1]} + {1'b0, kk[0]};
    pp_ext   = {62'd0, mul_r[63:0]};
    resp     = spin_r[j_r] ? hresp_r : lresp_r;
    wext     = {{9{cpl_q_r[15]}}, cpl_q_r};
    diff     = {hresp_r[1], hresp_r} - {lresp_r[1], lresp_r};
    prod     = mul_r[41:0];
    base     = '0;
    fsum     = '0;
    cterm    = '0;
    qsat     = '0;
    load_out = 1'b0;

    state_nxt    = state_r;
    term_nxt     = term_r;
    csum_nxt     = csum_r;
    n_nxt        = n_r;
    e_nxt        = e_r;
    m_nxt        = m_r;
    pacc_nxt     = pacc_r;
    pp_cnt_nxt   = pp_cnt_r;
    spin_nxt     = spin_r;
    pin_nxt      = pin_r;
    site_nxt     = site_r;
    site_sw_nxt  = site_sw_r;
    in_range_nxt = in_range_r;
    draw_nxt     = draw_r;
    j_nxt        = j_r;
    facc_nxt     = facc_r;
    field_nxt    = field_r;
    prob_nxt     = prob_r;

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_site_nxt  = out_site_r;
    out_spin_nxt  = out_spin_r;
    out_prob_nxt  = out_prob_r;
    out_field_nxt = out_field_r;

    mul_a = '0;
    mul_b = '0;

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = den;

    rom_we    = 1'b0;
    rom_waddr = m_r;
    rom_wdata = '0;
    rom_raddr = '0;

    cpl_we    = 1'b0;
    cpl_waddr = {site_sw, nb_sw};
    cpl_raddr = {j_r, site_sw_r};
    thr_we    = 1'b0;

    unique case (state_r)
      // exp(-1/16) by its series, one division per term
      ST_SER_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = term_r;
        div_req.divisor  = {{(DIVISOR_W-9){1'b0}}, n_r, 4'b0000};
        state_nxt        = ST_SER_WAIT;
      end
      ST_SER_WAIT: begin
        if (div_rsp.done) begin
          term_nxt = div_rsp.quotient;
          csum_nxt = n_r[0] ? csum_r - div_rsp.quotient : csum_r + div_rsp.quotient;
          n_nxt    = n_r + 5'd1;
          if (n_r == SERIES_LAST) begin
            e_nxt     = DIVIDEND_W'(1) << 62;
            m_nxt     = '0;
            state_nxt = ST_POS_GO;
          end else begin
            state_nxt = ST_SER_GO;
          end
        end
      end
      // positive x entry: 2^62 / den
      ST_POS_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(1) << 62;
        state_nxt        = ST_POS_WAIT;
      end
      ST_POS_WAIT: begin
        if (div_rsp.done) begin
          rom_we    = 1'b1;
          rom_waddr = m_r;
          rom_wdata = (|div_rsp.quotient[DIVIDEND_W-1:16]) ? 16'hFFFF
                                                           : div_rsp.quotient[15:0];
          state_nxt = (m_r != '0) ? ST_NEG_GO : ST_EXP_MUL;
          pacc_nxt   = '0;
          pp_cnt_nxt = '0;
        end
      end
      // negative x entry: (e truncated to 46 fraction bits) / den
      ST_NEG_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {e_r[DIVIDEND_W-1:16], 16'h0000};
        state_nxt        = ST_NEG_WAIT;
      end
      ST_NEG_WAIT: begin
        if (div_rsp.done) begin
          rom_we     = 1'b1;
          rom_waddr  = ~m_r + 9'd1;
          rom_wdata  = (|div_rsp.quotient[DIVIDEND_W-1:16]) ? 16'hFFFF
                                                            : div_rsp.quotient[15:0];
          pacc_nxt   = '0;
          pp_cnt_nxt = '0;
          state_nxt  = (m_r == MAG_LAST) ? ST_IDLE : ST_EXP_MUL;
        end
      end
      // e = e * c >> 62 from four 32-bit partial products
      ST_EXP_MUL: begin
        if (pp_cnt_r != 3'd4) begin
          mul_a = pp_cnt_r[1] ? {2'b00, e_r[DIVIDEND_W-1:32]} : {1'b0, e_r[31:0]};
          mul_b = pp_cnt_r[0] ? {2'b00, csum_r[DIVIDEND_W-1:32]}
                              : {1'b0, csum_r[31:0]};
        end
        if (pp_cnt_r != 3'd0) begin
          case (sh)
            2'd0:    pacc_nxt = pacc_r + pp_ext;
            2'd1:    pacc_nxt = pacc_r + (pp_ext << 32);
            2'd2:    pacc_nxt = pacc_r + (pp_ext << 64);
            default: pacc_nxt = pacc_r;
          endcase
        end
        pp_cnt_nxt = pp_cnt_r + 3'd1;
        if (pp_cnt_r == 3'd4) begin
          e_nxt     = pacc_nxt[124:62];
          m_nxt     = m_r + 9'd1;
          state_nxt = ((m_r + 9'd1) == MAG_LAST) ? ST_NEG_GO : ST_POS_GO;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          site_nxt     = in_chan.site_index;
          site_sw_nxt  = site_sw;
          in_range_nxt = site_ok;
          draw_nxt     = in_chan.uniform_draw;
          field_nxt    = '0;
          prob_nxt     = '0;
          state_nxt    = ST_RESP;
          unique case (op_t'(in_chan.opcode))
            OP_WR_COUPLING:  cpl_we = site_ok && nb_ok;
            OP_WR_THRESHOLD: thr_we = site_ok;
            OP_WR_SPIN: begin
              if (site_ok) begin
                spin_nxt[site_sw] = in_chan.spin_bit;
                pin_nxt[site_sw]  = in_chan.pin_flag;
              end
            end
            OP_UPDATE: begin
              if (site_ok && !pin_r[site_sw]) begin
                state_nxt = ST_UPD_RD;
              end
            end
          endcase
        end
      end
      // first coupling and threshold read
      ST_UPD_RD: begin
        cpl_raddr = {SW'(0), site_sw_r};
        j_nxt     = '0;
        state_nxt = ST_UPD_ACC;
      end
      // one coupling per cycle, column of the updated site
      ST_UPD_ACC: begin
        unique case (resp)
          2'b00: cterm = '0;
          2'b01: cterm = wext;
          2'b11: cterm = -wext;
          2'b10: cterm = -(wext <<< 1);
        endcase
        base     = (j_r == '0) ? 25'({{9{thr_q_r[15]}}, thr_q_r}) : facc_r;
        fsum     = base + ((j_r != site_sw_r) ? cterm : 25'sd0);
        facc_nxt = fsum;
        cpl_raddr = {(j_r == SW'(NUM_SITES - 1)) ? j_r : j_r + 1'b1, site_sw_r};
        j_nxt    = j_r + 1'b1;
        if (j_r == SW'(NUM_SITES - 1)) begin
          // saturate the field to 23 bits
          if (fsum[24:22] == 3'b000 || fsum[24:22] == 3'b111) begin
            field_nxt = fsum[22:0];
          end else if (fsum[24]) begin
            field_nxt = 23'sh400000;
          end else begin
            field_nxt = 23'sh3FFFFF;
          end
          state_nxt = ST_UPD_BETA;
        end
      end
      // beta times response spread
      ST_UPD_BETA: begin
        mul_a     = {17'd0, beta_r};
        mul_b     = {{30{diff[2]}}, diff};
        state_nxt = ST_UPD_PROD;
      end
      // then times the field
      ST_UPD_PROD: begin
        mul_a     = {{14{mul_r[18]}}, mul_r[18:0]};
        mul_b     = {{10{field_r[22]}}, field_r};
        state_nxt = ST_UPD_SAT;
      end
      // floor to sixteenths, clamp to the rom range, read the rom
      ST_UPD_SAT: begin
        if (prod[41:24] == '0 || prod[41:24] == '1) begin
          qsat = prod[24:16];
        end else if (prod[41]) begin
          qsat = 9'h100;
        end else begin
          qsat = 9'h0FF;
        end
        rom_raddr = qsat;
        state_nxt = ST_UPD_SPIN;
      end
      ST_UPD_SPIN: begin
        prob_nxt            = rom_q_r;
        spin_nxt[site_sw_r] = draw_r < rom_q_r;
        state_nxt           = ST_RESP;
      end
      // hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_site_nxt  = site_r;
      out_spin_nxt  = in_range_r ? spin_r[site_sw_r] : 1'b0;
      out_prob_nxt  = prob_r;
      out_field_nxt = field_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SER_GO;
      term_r      <= DIVIDEND_W'(1) << 62;
      csum_r      <= DIVIDEND_W'(1) << 62;
      n_r         <= 5'd1;
      beta_r      <= BETA_RESET;
      lresp_r     <= LOW_RESP_RESET;
      hresp_r     <= HIGH_RESP_RESET;
      spin_r      <= '0;
      pin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      csum_r      <= csum_nxt;
      n_r         <= n_nxt;
      beta_r      <= beta_nxt;
      lresp_r     <= lresp_nxt;
      hresp_r     <= hresp_nxt;
      spin_r      <= spin_nxt;
      pin_r       <= pin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r         <= e_nxt;
    m_r         <= m_nxt;
    pacc_r      <= pacc_nxt;
    pp_cnt_r    <= pp_cnt_nxt;
    mul_r       <= mul_a * mul_b;
    site_r      <= site_nxt;
    site_sw_r   <= site_sw_nxt;
    in_range_r  <= in_range_nxt;
    draw_r      <= draw_nxt;
    j_r         <= j_nxt;
    facc_r      <= facc_nxt;
    field_r     <= field_nxt;
    prob_r      <= prob_nxt;
    out_site_r  <= out_site_nxt;
    out_spin_r  <= out_spin_nxt;
    out_prob_r  <= out_prob_nxt;
    out_field_r <= out_field_nxt;
  end

  // sigmoid rom, filled after reset, indexed by x in sixteenths
  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom[rom_waddr] <= rom_wdata;
    end
    rom_q_r <= rom[rom_raddr];
  end

  // coupling memory, row = site written, column = neighbour
  always_ff @(posedge clk) begin
    if (cpl_we) begin
      cpl_mem[cpl_waddr] <= in_chan.weight_value;
    end
    cpl_q_r <= cpl_mem[cpl_raddr];
  end

  // threshold memory
  always_ff @(posedge clk) begin
    if (thr_we) begin
      thr_mem[site_sw_nxt] <= in_chan.weight_value;
    end
    thr_q_r <= thr_mem[site_sw_r];
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("input accepted twice in a row");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_rom_fill_only: assert property (@(posedge clk) disable iff (!rst_n)
    rom_we |-> !in_chan.ready)
    else $error("rom written outside the fill pass");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result raised outside the result state");

endmodule

>>> rtl/igs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module igs_div import igs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;

  always_comb begin
    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] trial;
    shifted  = {rem_r, quo_r[DIVIDEND_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[DIVISOR_W]) begin
        rem_nxt = trial[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

endmodule
